/* hw/rtl/rfd_pkg.sv */
package rfd_pkg;

   // Controller states: load words, issue a memory read, fill the output register
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ISSUE,
      ST_FILL
   } state_type;

   // Rail numbers of the zig-zag
   typedef enum logic [1:0] {
      RAIL_TOP,
      RAIL_MID,
      RAIL_BOT
   } rail_type;

   localparam int CHAR_W = 8;

endpackage

/* hw/rtl/rail_fence_decrypt_three_rails.sv */
// Three-rail fence decryption. Ciphertext words arrive on the req_ stream, one byte
// each, and are written into an internal store of MAX_LEN bytes at one word per
// cycle. Bytes beyond MAX_LEN are dropped and every plaintext word of that message
// then carries the overflow flag in rsp_tuser. The word marked with req_tlast
// starts the readout: the stored text is taken as rail segments in the order
// bottom, top, middle, and the plaintext is rebuilt by walking the zig-zag
// 0,1,2,1. Each plaintext word passes through ST_ISSUE, which makes the store's
// registered read once the output register is empty or being taken, and then
// ST_FILL, which loads the output register. No input is taken during the readout;
// the next message may start while the final plaintext word still waits on rsp_.
module rail_fence_decrypt_three_rails
   import rfd_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [CHAR_W-1:0] req_tdata,   // [7:0] cipher_char
   input  logic              req_tlast,   // last_in
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [CHAR_W-1:0] rsp_tdata,   // [7:0] plain_char
   output logic              rsp_tlast,   // last_out
   output logic              rsp_tuser    // [0] overflow
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

   logic [CHAR_W-1:0] message_store [MAX_LEN];

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              ovf_msg_ff, ovf_msg_in;
   logic [CW-1:0]     n_ff, n_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [CW-1:0]     ptr0_ff, ptr0_in;
   logic [CW-1:0]     ptr1_ff, ptr1_in;
   logic [CW-1:0]     ptr2_ff, ptr2_in;
   logic              last_pend_ff, last_pend_in;
   logic [CHAR_W-1:0] rd_data_ff;
   logic              out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0] out_data_ff, out_data_in;
   logic              out_last_ff, out_last_in;
   logic              out_ovf_ff, out_ovf_in;

   logic              req_fire;
   logic              has_room;
   logic              issue;
   logic [CW-1:0]     n_next;
   logic [CW:0]       len0_w;
   logic [CW:0]       len2_w;
   rail_type          rail;
   logic [CW-1:0]     rd_addr;

   // Handshake and phase decode
   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign has_room   = (count_ff < MAX_CNT);
   assign issue      = (state_ff == ST_ISSUE) && (!out_valid_ff || rsp_tready);

   // Rail lengths of the finished message
   assign n_next = has_room ? count_ff + CW'(1) : count_ff;
   assign len0_w = ({1'b0, n_next} + (CW+1)'(3)) >> 2;
   assign len2_w = ({1'b0, n_next} + (CW+1)'(1)) >> 2;

   // Pick the rail of the current zig-zag position
   always_comb begin
      case (k_ff[1:0])
         2'd0:    rail = RAIL_TOP;
         2'd2:    rail = RAIL_BOT;
         default: rail = RAIL_MID;
      endcase
   end

   always_comb begin
      case (rail)
         RAIL_TOP: rd_addr = ptr0_ff;
         RAIL_BOT: rd_addr = ptr2_ff;
         default:  rd_addr = ptr1_ff;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:  if (req_fire && req_tlast) state_in = ST_ISSUE;
         ST_ISSUE: if (issue) state_in = ST_FILL;
         ST_FILL:  state_in = last_pend_ff ? ST_LOAD : ST_ISSUE;
         default:  state_in = ST_LOAD;
      endcase
   end

   // Datapath next values
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      ovf_msg_in   = ovf_msg_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      ptr0_in      = ptr0_ff;
      ptr1_in      = ptr1_ff;
      ptr2_in      = ptr2_ff;
      last_pend_in = last_pend_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (req_tlast) begin
                  // close the message and set up the segment pointers
                  count_in   = '0;
                  ovf_in     = 1'b0;
                  ovf_msg_in = ovf_ff || !has_room;
                  n_in       = n_next;
                  k_in       = '0;
                  ptr2_in    = '0;
                  ptr0_in    = len2_w[CW-1:0];
                  ptr1_in    = len2_w[CW-1:0] + len0_w[CW-1:0];
               end else begin
                  count_in = n_next;
                  ovf_in   = ovf_ff || !has_room;
               end
            end
         end
         ST_ISSUE: begin
            if (issue) begin
               // advance the visited rail and the position
               case (rail)
                  RAIL_TOP: ptr0_in = ptr0_ff + CW'(1);
                  RAIL_BOT: ptr2_in = ptr2_ff + CW'(1);
                  default:  ptr1_in = ptr1_ff + CW'(1);
               endcase
               k_in         = k_ff + CW'(1);
               last_pend_in = (k_ff + CW'(1) == n_ff);
            end
         end
         ST_FILL: begin
            out_valid_in = 1'b1;
            out_data_in  = rd_data_ff;
            out_last_in  = last_pend_ff;
            out_ovf_in   = ovf_msg_ff;
         end
         default: ;
      endcase
   end

   // Message store: write on load, registered read on issue
   always_ff @(posedge clock) begin
      if (req_fire && has_room) begin
         message_store[count_ff[AW-1:0]] <= req_tdata;
      end
      if (issue) begin
         rd_data_ff <= message_store[rd_addr[AW-1:0]];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         last_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
         last_pend_ff <= last_pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ovf_msg_ff  <= ovf_msg_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      ptr0_ff     <= ptr0_in;
      ptr1_ff     <= ptr1_in;
      ptr2_ff     <= ptr2_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("byte count beyond store depth");

   a_issue_in_message: assert property (@(posedge clock) disable iff (reset)
      issue |-> (rd_addr < n_ff) && (k_ff < n_ff))
      else $error("read outside stored message");

   a_fill_after_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> ($past(state_ff) == ST_ISSUE) && !out_valid_ff)
      else $error("output register loaded while occupied");

   a_no_accept_in_readout: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> !req_tready)
      else $error("input taken during readout");

endmodule
